[rtl/tsbs_pkg.sv]
package tsbs_pkg;

    localparam int BUCKETS = 5;
    localparam int TOKW    = 25;
    localparam int DELTAW  = 20;

    localparam logic [TOKW-1:0]   MICRO     = 25'd1000000;
    localparam logic [DELTAW-1:0] DELTA_CAP = 20'd1000000;
    localparam logic [9:0]        MS_TO_US  = 10'd1000;

    localparam logic [4:0]      REFILL_RATE [BUCKETS] = '{5'd8, 5'd6, 5'd2, 5'd2, 5'd20};
    localparam logic [TOKW-1:0] BURST_CAP   [BUCKETS] =
        '{25'd8000000, 25'd8000000, 25'd2000000, 25'd2000000, 25'd20000000};
    localparam logic [2:0]      GLOBAL_BKT  = 3'd4;
    localparam logic [2:0]      LAST_BKT    = 3'd4;

    localparam logic CFG_RESERVE = 1'b0;
    localparam logic CFG_LIMIT   = 1'b1;

    typedef enum logic [1:0] {
        FUNC_SUBMIT = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_DONE   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        EV_ACCEPT = 2'd0,
        EV_REJECT = 2'd1,
        EV_DONE   = 2'd2,
        EV_LAUNCH = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_STALE = 2'd1,
        ST_RADIO = 2'd2,
        ST_UNUSED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SL_FREE   = 2'd0,
        SL_QUEUED = 2'd1,
        SL_FLIGHT = 2'd2,
        SL_SPARE  = 2'd3
    } t_slot_state;

    typedef struct packed {
        logic        send_ok;
        logic        clock_sensitive;
        logic [63:0] merge_key;
        logic        mergeable;
        logic [63:0] expiry_at_us;
        logic [63:0] earliest_us;
        logic [1:0]  bucket;
        logic [2:0]  priority_req;
        logic [31:0] frame_id;
        logic [63:0] now_us;
    } t_in_item;

    typedef struct packed {
        logic capture;
        logic sub_step;
        logic sub_dec;
        logic emit_rej;
        logic emit_stale;
        logic sub_write;
        logic tk_delta;
        logic tk_refill;
        logic tk_step;
        logic tk_launch;
        logic cmp;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic inflight_vld;
        logic scan_last;
        logic bkt_last;
        logic out_free;
        logic pend_vld;
        logic reject;
        logic has_repl;
        logic expire_now;
        logic best_vld;
    } t_sts;

endpackage

[rtl/tsbs_ctrl.sv]
module tsbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_func,
    input  tsbs_pkg::t_sts  i_sts,
    output logic            o_idle,
    output tsbs_pkg::t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_SUB_SCAN  = 11'b00000000010,
        S_SUB_DEC   = 11'b00000000100,
        S_SUB_ACT   = 11'b00000001000,
        S_SUB_WR    = 11'b00000010000,
        S_TK_DELTA  = 11'b00000100000,
        S_TK_REFILL = 11'b00001000000,
        S_TK_SCAN   = 11'b00010000000,
        S_TK_LAUNCH = 11'b00100000000,
        S_CMP       = 11'b01000000000,
        S_FLUSH     = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (tsbs_pkg::t_func'(i_in_func))
                        tsbs_pkg::FUNC_SUBMIT: n_state = S_SUB_SCAN;
                        tsbs_pkg::FUNC_TICK:   n_state = S_TK_DELTA;
                        tsbs_pkg::FUNC_DONE:   n_state = S_CMP;
                        default:               n_state = S_FLUSH;
                    endcase
                end
            end
            S_SUB_SCAN: begin
                o_cmd.sub_step = 1'b1;
                if (i_sts.scan_last) n_state = S_SUB_DEC;
            end
            S_SUB_DEC: begin
                o_cmd.sub_dec = 1'b1;
                n_state = S_SUB_ACT;
            end
            S_SUB_ACT: begin
                if (i_sts.reject) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_rej = 1'b1;
                        n_state = S_FLUSH;
                    end
                end else if (i_sts.has_repl) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit_stale = 1'b1;
                        n_state = S_SUB_WR;
                    end
                end else begin
                    n_state = S_SUB_WR;
                end
            end
            S_SUB_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.sub_write = 1'b1;
                    n_state = S_FLUSH;
                end
            end
            S_TK_DELTA: begin
                if (i_sts.inflight_vld) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.tk_delta = 1'b1;
                    n_state = S_TK_REFILL;
                end
            end
            S_TK_REFILL: begin
                o_cmd.tk_refill = 1'b1;
                if (i_sts.bkt_last) n_state = S_TK_SCAN;
            end
            S_TK_SCAN: begin
                if (!i_sts.expire_now || i_sts.out_free) begin
                    o_cmd.tk_step = 1'b1;
                    if (i_sts.scan_last) n_state = S_TK_LAUNCH;
                end
            end
            S_TK_LAUNCH: begin
                if (!i_sts.best_vld) begin
                    n_state = S_FLUSH;
                end else if (i_sts.out_free) begin
                    o_cmd.tk_launch = 1'b1;
                    n_state = S_FLUSH;
                end
            end
            S_CMP: begin
                if (!i_sts.inflight_vld) begin
                    n_state = S_FLUSH;
                end else if (i_sts.out_free) begin
                    o_cmd.cmp = 1'b1;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_vld) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> !o_idle)
        else $error("capture did not leave idle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.flush || o_cmd.emit_rej || o_cmd.sub_write || o_cmd.tk_launch || o_cmd.cmp)
        |-> i_sts.out_free)
        else $error("result issued into a full output register");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TK_SCAN && i_sts.expire_now && !i_sts.out_free) |=> $stable(r_state))
        else $error("scan advanced past an expiry without emitting");

endmodule

[rtl/tsbs_dp.sv]
module tsbs_dp #(
    parameter int SLOT_COUNT = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [295:0]        i_in_data,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic [15:0]         i_cfg_wdata,
    input  tsbs_pkg::t_cmd      i_cmd,
    output tsbs_pkg::t_sts      o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_out_event,
    output logic [31:0]         o_out_request,
    output logic [1:0]          o_out_status,
    output logic [2:0]          o_out_slot,
    output logic                o_out_last
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);

    tsbs_pkg::t_in_item r_in;

    logic [3:0]  r_reserve;
    logic [15:0] r_limit;

    logic [1:0] r_status [SLOT_COUNT];
    logic [2:0] r_prio   [SLOT_COUNT];
    logic [1:0] r_bkt    [SLOT_COUNT];
    logic       r_mflag  [SLOT_COUNT];

    logic [31:0] r_req [SLOT_COUNT];
    logic [63:0] r_nb  [SLOT_COUNT];
    logic [63:0] r_exp [SLOT_COUNT];
    logic [63:0] r_enq [SLOT_COUNT];
    logic [63:0] r_key [SLOT_COUNT];

    logic [tsbs_pkg::TOKW-1:0] r_tok [tsbs_pkg::BUCKETS];
    logic [63:0] r_last_refill;
    logic        r_inflight_vld;
    logic [SW-1:0] r_inflight_idx;

    logic [SW-1:0] r_idx;
    logic [2:0]    r_bcnt;
    logic          r_free_vld, r_shed_vld, r_repl_vld, r_best_vld;
    logic [SW-1:0] r_free_idx, r_shed_idx, r_repl_idx, r_best_idx;
    logic [2:0]    r_shed_prio, r_best_prio;
    logic [63:0]   r_best_time;
    logic [CW-1:0] r_used;
    logic [SW-1:0] r_target;
    logic          r_has_repl, r_reject;
    logic [63:0]   r_deadline;
    logic [tsbs_pkg::DELTAW-1:0] r_delta;

    logic        r_out_vld, r_out_last;
    logic [1:0]  r_out_ev, r_out_st;
    logic [31:0] r_out_req;
    logic [SW-1:0] r_out_slot;
    logic        r_pend_vld;
    logic [1:0]  r_pend_ev, r_pend_st;
    logic [31:0] r_pend_req;
    logic [SW-1:0] r_pend_slot;

    tsbs_pkg::t_in_item in_now;
    logic        out_free;
    logic [SW-1:0] rd_idx;
    logic [31:0] rd_req;
    logic        cur_queued, cur_expired, expire_now, cur_eligible, cur_better;
    logic        sh_better, rp_match;
    logic        dec_repl_vld;
    logic [SW-1:0] dec_repl_idx, dec_target;
    logic        dec_target_vld;
    logic [CW-1:0] dec_used;
    logic        dec_reject;
    logic [64:0] dl_sum;
    logic [25:0] dl_span;
    logic [63:0] diff;
    logic [tsbs_pkg::DELTAW-1:0] delta_new;
    logic [tsbs_pkg::TOKW-1:0]   refill_prod;
    logic [tsbs_pkg::TOKW:0]     refill_sum;
    logic [tsbs_pkg::TOKW-1:0]   refill_val;
    logic [63:0] new_exp;
    logic        emit_any;
    logic [1:0]  e_ev, e_st;
    logic [31:0] e_req;
    logic [SW-1:0] e_slot;
    logic [SLOT_COUNT-1:0] flight_vec;

    assign in_now   = i_in_data;
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        if (i_cmd.emit_stale) rd_idx = r_target;
        else if (i_cmd.tk_launch) rd_idx = r_best_idx;
        else if (i_cmd.cmp) rd_idx = r_inflight_idx;
        else rd_idx = r_idx;
    end
    assign rd_req = r_req[rd_idx];

    // per-slot scan terms
    assign cur_queued  = (r_status[r_idx] == tsbs_pkg::SL_QUEUED);
    assign cur_expired = (r_exp[r_idx] != 64'd0) && (r_in.now_us >= r_exp[r_idx]);
    assign expire_now  = cur_queued && cur_expired;
    assign cur_eligible = cur_queued && !cur_expired && (r_nb[r_idx] <= r_in.now_us)
        && (r_tok[{1'b0, r_bkt[r_idx]}] >= tsbs_pkg::MICRO)
        && (r_tok[tsbs_pkg::GLOBAL_BKT] >= tsbs_pkg::MICRO);
    assign cur_better = !r_best_vld || (r_prio[r_idx] < r_best_prio)
        || ((r_prio[r_idx] == r_best_prio) && (r_enq[r_idx] < r_best_time));
    assign sh_better = cur_queued && (r_prio[r_idx] > r_in.priority_req)
        && (!r_shed_vld || (r_prio[r_idx] > r_shed_prio));
    assign rp_match = cur_queued && r_in.mergeable && r_mflag[r_idx]
        && (r_key[r_idx] == r_in.merge_key);

    // placement decision
    always_comb begin
        dec_repl_vld = r_repl_vld;
        dec_repl_idx = r_repl_idx;
        if (!r_repl_vld && (!r_free_vld || ((r_in.priority_req != 3'd0)
            && (7'(r_used) + 7'(r_reserve) >= 7'(SLOT_COUNT))))) begin
            dec_repl_vld = r_shed_vld;
            dec_repl_idx = r_shed_idx;
        end
        dec_used       = r_used - CW'(dec_repl_vld);
        dec_target_vld = dec_repl_vld || r_free_vld;
        dec_target     = dec_repl_vld ? dec_repl_idx : r_free_idx;
        dec_reject     = !dec_target_vld || ((r_in.priority_req != 3'd0)
            && (7'(dec_used) + 7'(r_reserve) >= 7'(SLOT_COUNT)));
    end

    assign dl_span = 26'(r_limit) * 26'(tsbs_pkg::MS_TO_US);
    assign dl_sum  = {1'b0, r_in.now_us} + 65'(dl_span);

    assign diff = r_in.now_us - r_last_refill;
    always_comb begin
        if (r_in.now_us < r_last_refill) delta_new = '0;
        else if (diff > 64'(tsbs_pkg::DELTA_CAP)) delta_new = tsbs_pkg::DELTA_CAP;
        else delta_new = diff[tsbs_pkg::DELTAW-1:0];
    end

    assign refill_prod = tsbs_pkg::TOKW'(r_delta) * tsbs_pkg::TOKW'(tsbs_pkg::REFILL_RATE[r_bcnt]);
    assign refill_sum  = {1'b0, r_tok[r_bcnt]} + {1'b0, refill_prod};
    assign refill_val  = (refill_sum > {1'b0, tsbs_pkg::BURST_CAP[r_bcnt]})
        ? tsbs_pkg::BURST_CAP[r_bcnt] : refill_sum[tsbs_pkg::TOKW-1:0];

    always_comb begin
        new_exp = r_in.expiry_at_us;
        if (r_in.clock_sensitive && ((r_in.expiry_at_us == 64'd0)
            || (r_in.expiry_at_us > r_deadline)))
            new_exp = r_deadline;
    end

    // result selection
    assign emit_any = i_cmd.emit_rej | i_cmd.emit_stale | i_cmd.sub_write
        | (i_cmd.tk_step & expire_now) | i_cmd.tk_launch | i_cmd.cmp;

    always_comb begin
        e_ev   = tsbs_pkg::EV_DONE;
        e_st   = tsbs_pkg::ST_OK;
        e_req  = rd_req;
        e_slot = r_idx;
        if (i_cmd.emit_rej) begin
            e_ev   = tsbs_pkg::EV_REJECT;
            e_req  = r_in.frame_id;
            e_slot = '0;
        end else if (i_cmd.emit_stale) begin
            e_st   = tsbs_pkg::ST_STALE;
            e_slot = r_target;
        end else if (i_cmd.sub_write) begin
            e_ev   = tsbs_pkg::EV_ACCEPT;
            e_req  = r_in.frame_id;
            e_slot = r_target;
        end else if (i_cmd.tk_launch) begin
            e_ev   = tsbs_pkg::EV_LAUNCH;
            e_slot = r_best_idx;
        end else if (i_cmd.cmp) begin
            e_st   = r_in.send_ok ? tsbs_pkg::ST_OK : tsbs_pkg::ST_RADIO;
            e_slot = r_inflight_idx;
        end else begin
            e_st   = tsbs_pkg::ST_STALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserve <= 4'd2;
            r_limit   <= 16'd500;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == tsbs_pkg::CFG_RESERVE) r_reserve <= i_cfg_wdata[3:0];
            if (i_cfg_index == tsbs_pkg::CFG_LIMIT) r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_in <= in_now;
        if (i_cmd.sub_dec) r_deadline <= dl_sum[64] ? '1 : dl_sum[63:0];
        if (i_cmd.tk_delta) r_delta <= delta_new;
        if (i_cmd.sub_write) begin
            r_req[r_target] <= r_in.frame_id;
            r_nb[r_target]  <= r_in.earliest_us;
            r_exp[r_target] <= new_exp;
            r_enq[r_target] <= r_in.now_us;
            r_key[r_target] <= r_in.merge_key;
        end
    end

    // slot state, buckets and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_status[i] <= tsbs_pkg::SL_FREE;
                r_prio[i]   <= '0;
                r_bkt[i]    <= '0;
                r_mflag[i]  <= 1'b0;
            end
            for (int b = 0; b < tsbs_pkg::BUCKETS; b++) r_tok[b] <= tsbs_pkg::BURST_CAP[b];
            r_last_refill  <= '0;
            r_inflight_vld <= 1'b0;
            r_inflight_idx <= '0;
            r_idx      <= '0;
            r_bcnt     <= '0;
            r_free_vld <= 1'b0;
            r_shed_vld <= 1'b0;
            r_repl_vld <= 1'b0;
            r_best_vld <= 1'b0;
            r_used     <= '0;
            r_has_repl <= 1'b0;
            r_reject   <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_idx      <= '0;
                r_bcnt     <= '0;
                r_free_vld <= 1'b0;
                r_shed_vld <= 1'b0;
                r_repl_vld <= 1'b0;
                r_best_vld <= 1'b0;
                r_used     <= '0;
            end
            if (i_cmd.sub_step) begin
                if (r_status[r_idx] == tsbs_pkg::SL_FREE) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_idx;
                end else begin
                    r_used <= r_used + CW'(1);
                end
                if (sh_better) begin
                    r_shed_vld  <= 1'b1;
                    r_shed_idx  <= r_idx;
                    r_shed_prio <= r_prio[r_idx];
                end
                if (rp_match) begin
                    r_repl_vld <= 1'b1;
                    r_repl_idx <= r_idx;
                end
                r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.sub_dec) begin
                r_target   <= dec_target;
                r_has_repl <= dec_repl_vld;
                r_reject   <= dec_reject;
            end
            if (i_cmd.sub_write) begin
                r_status[r_target] <= tsbs_pkg::SL_QUEUED;
                r_prio[r_target]   <= r_in.priority_req;
                r_bkt[r_target]    <= r_in.bucket;
                r_mflag[r_target]  <= r_in.mergeable;
            end
            if (i_cmd.tk_delta) r_last_refill <= r_in.now_us;
            if (i_cmd.tk_refill) begin
                r_tok[r_bcnt] <= refill_val;
                r_bcnt <= r_bcnt + 3'd1;
            end
            if (i_cmd.tk_step) begin
                if (expire_now) begin
                    r_status[r_idx] <= tsbs_pkg::SL_FREE;
                end else if (cur_eligible && cur_better) begin
                    r_best_vld  <= 1'b1;
                    r_best_idx  <= r_idx;
                    r_best_prio <= r_prio[r_idx];
                    r_best_time <= r_enq[r_idx];
                end
                r_idx <= r_idx + SW'(1);
            end
            if (i_cmd.tk_launch) begin
                r_status[r_best_idx] <= tsbs_pkg::SL_FLIGHT;
                r_inflight_vld <= 1'b1;
                r_inflight_idx <= r_best_idx;
                r_tok[{1'b0, r_bkt[r_best_idx]}] <=
                    r_tok[{1'b0, r_bkt[r_best_idx]}] - tsbs_pkg::MICRO;
                r_tok[tsbs_pkg::GLOBAL_BKT] <= r_tok[tsbs_pkg::GLOBAL_BKT] - tsbs_pkg::MICRO;
            end
            if (i_cmd.cmp) begin
                r_status[r_inflight_idx] <= tsbs_pkg::SL_FREE;
                r_inflight_vld <= 1'b0;
            end
        end
    end

    // one result held back so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (emit_any) begin
            r_out_vld   <= r_pend_vld;
            r_out_ev    <= r_pend_ev;
            r_out_st    <= r_pend_st;
            r_out_req   <= r_pend_req;
            r_out_slot  <= r_pend_slot;
            r_out_last  <= 1'b0;
            r_pend_vld  <= 1'b1;
            r_pend_ev   <= e_ev;
            r_pend_st   <= e_st;
            r_pend_req  <= e_req;
            r_pend_slot <= e_slot;
        end else if (i_cmd.flush) begin
            r_out_vld  <= 1'b1;
            r_out_ev   <= r_pend_ev;
            r_out_st   <= r_pend_st;
            r_out_req  <= r_pend_req;
            r_out_slot <= r_pend_slot;
            r_out_last <= 1'b1;
            r_pend_vld <= 1'b0;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_out_event   = r_out_ev;
    assign o_out_request = r_out_req;
    assign o_out_status  = r_out_st;
    assign o_out_slot    = 3'(r_out_slot);
    assign o_out_last    = r_out_last;

    assign o_sts.inflight_vld = r_inflight_vld;
    assign o_sts.scan_last    = (r_idx == LAST_IDX);
    assign o_sts.bkt_last     = (r_bcnt == tsbs_pkg::LAST_BKT);
    assign o_sts.out_free     = out_free;
    assign o_sts.pend_vld     = r_pend_vld;
    assign o_sts.reject       = r_reject;
    assign o_sts.has_repl     = r_has_repl;
    assign o_sts.expire_now   = expire_now;
    assign o_sts.best_vld     = r_best_vld;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++)
            flight_vec[i] = (r_status[i] == tsbs_pkg::SL_FLIGHT);
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight_vld |-> (r_status[r_inflight_idx] == tsbs_pkg::SL_FLIGHT))
        else $error("in-flight slot not marked in flight");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(flight_vec) <= 1)
        else $error("more than one slot in flight");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit_any && !out_free))
        else $error("result produced while output register full");

endmodule

[rtl/tx_slot_token_bucket_scheduler.sv]
// submit: scan, decide, then reject or write; tick: delta, refill, scan, launch
// tick steps skipped while a slot is in flight; completion: compare; plus output waits
// one request at a time, bucket refill one bucket per cycle, slot scan one slot per cycle,
// held on a tick expiry while output is full; a final result goes valid as tready returns
// results are held one deep so the final result of a request carries tlast
// synchronous active-low reset: all slots free, buckets full, nothing in flight
module tx_slot_token_bucket_scheduler #(
    parameter int SLOT_COUNT = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // now_us, frame_id, priority_req, bucket, earliest_us, expiry_at_us,
    // mergeable, merge_key, clock_sensitive, send_ok
    input  logic [295:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_request, status, slot_index, zero pad
    output logic [39:0]  m_axis_tdata,
    // event_res
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_wdata
);

    tsbs_pkg::t_cmd cmd;
    tsbs_pkg::t_sts sts;
    logic           idle;
    logic [31:0]    out_req;
    logic [1:0]     out_st;
    logic [2:0]     out_slot;

    tsbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_func  (s_axis_tuser),
        .i_sts      (sts),
        .o_idle     (idle),
        .o_cmd      (cmd)
    );

    tsbs_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_event   (m_axis_tuser),
        .o_out_request (out_req),
        .o_out_status  (out_st),
        .o_out_slot    (out_slot),
        .o_out_last    (m_axis_tlast)
    );

    assign s_axis_tready = idle;
    assign m_axis_tdata  = {3'b000, out_slot, out_st, out_req};

endmodule
